@@ src/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and the segment table for the signed pair scan core.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int unsigned NUM_DIGITS     = 6;
    localparam int unsigned GROUP_DIGITS   = 3;
    localparam int unsigned POS_W          = 3;
    localparam int unsigned CODE_W         = 4;
    localparam int unsigned VALUE_W        = 16;
    localparam int unsigned SEG_W          = 8;

    localparam logic [CODE_W-1:0]     CODE_BLANK     = 4'd10;
    localparam logic [CODE_W-1:0]     CODE_MINUS     = 4'd11;
    localparam logic [SEG_W-1:0]      SEG_OFF        = 8'hFF;
    localparam logic [NUM_DIGITS-1:0] SELECT_ALL_OFF = 6'h3F;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Last position of each value group
    localparam logic [POS_W-1:0] POS_FIRST_TOP  = 3'd2;
    localparam logic [POS_W-1:0] POS_SECOND_TOP = 3'd5;

    // Store write transaction from the sequencer
    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [CODE_W-1:0] code;
    } t_wr;

    // Active-low segment pattern for a digit code; bit 7 is the minus segment
    function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] s;
        unique case (code)
            4'd0:    s = 8'hA0;
            4'd1:    s = 8'hBE;
            4'd2:    s = 8'h62;
            4'd3:    s = 8'h2A;
            4'd4:    s = 8'h3C;
            4'd5:    s = 8'h29;
            4'd6:    s = 8'h21;
            4'd7:    s = 8'hBA;
            4'd8:    s = 8'h20;
            4'd9:    s = 8'h28;
            4'd11:   s = 8'h7F;
            default: s = SEG_OFF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ src/sps_div10.sv @@
// ----------------------------------------------------------------------------
// sps_div10
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder by
// subtracting ten times the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_div10 (
    input  wire logic [sps_pkg::VALUE_W-1:0] i_value,
    output logic      [sps_pkg::VALUE_W-1:0] o_quot,
    output logic      [sps_pkg::CODE_W-1:0]  o_rem
);

    localparam logic [16:0] RECIP = 17'd52429;   // ceil(2^19 / 10)
    localparam int unsigned SHIFT = 19;

    logic [32:0]                   prod;
    logic [sps_pkg::VALUE_W-1:0]   times_ten;
    logic [sps_pkg::VALUE_W-1:0]   diff;

    // Exact for every 16-bit unsigned input
    assign prod      = {17'd0, i_value} * {16'd0, RECIP};
    assign o_quot    = sps_pkg::VALUE_W'(prod >> SHIFT);
    assign times_ten = (o_quot << 3) + (o_quot << 1);
    assign diff      = i_value - times_ten;
    assign o_rem     = diff[sps_pkg::CODE_W-1:0];

endmodule

`default_nettype wire

@@ src/sps_digit_store.sv @@
// ----------------------------------------------------------------------------
// sps_digit_store
// Six digit codes with a write port from the sequencer and a registered scan
// port that decodes one position to segment and select patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_digit_store (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sps_pkg::t_wr                        i_wr,
    input  wire logic                                i_scan,
    input  wire logic [sps_pkg::POS_W-1:0]           i_scan_idx,
    output logic                                     o_strobe,
    output logic      [sps_pkg::SEG_W-1:0]           o_segments,
    output logic      [sps_pkg::NUM_DIGITS-1:0]      o_digit_select
);

    logic [sps_pkg::CODE_W-1:0]     r_codes [sps_pkg::NUM_DIGITS];
    logic                           r_strobe;
    logic [sps_pkg::SEG_W-1:0]      r_seg;
    logic [sps_pkg::NUM_DIGITS-1:0] r_sel;
    logic [sps_pkg::SEG_W-1:0]      n_seg;
    logic [sps_pkg::NUM_DIGITS-1:0] n_sel;
    logic                           idx_ok;

    // Code store, blank after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sps_pkg::NUM_DIGITS; i++) begin
                r_codes[i] <= sps_pkg::CODE_BLANK;
            end
        end else if (i_wr.en) begin
            r_codes[i_wr.addr] <= i_wr.code;
        end
    end

    // Decode of the scanned position; out-of-range index lights nothing
    assign idx_ok = (i_scan_idx < sps_pkg::POS_W'(sps_pkg::NUM_DIGITS));

    always_comb begin
        n_seg = sps_pkg::SEG_OFF;
        n_sel = sps_pkg::SELECT_ALL_OFF;
        if (idx_ok) begin
            n_seg = sps_pkg::seg_of(r_codes[i_scan_idx]);
            n_sel = sps_pkg::SELECT_ALL_OFF
                    & ~(sps_pkg::NUM_DIGITS'(1) << i_scan_idx);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan) begin
            r_seg <= n_seg;
            r_sel <= n_sel;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_segments     = r_seg;
    assign o_digit_select = r_sel;

endmodule

`default_nettype wire

@@ src/signed_pair_seven_segment_scan_core.sv @@
// ----------------------------------------------------------------------------
// signed_pair_seven_segment_scan_core
// Six-digit multiplexed display driver for a pair of signed values.
// ----------------------------------------------------------------------------
// Usage: present a transaction on i_cmd and its fields with start high; it is
// taken at a rising edge where busy is low.
// Load (i_cmd = 0): both values are split into decimal digit codes, one digit
// per cycle through a single shared divide-by-ten unit. busy is high while
// the six digits are written; no result is produced.
// Scan (i_cmd = 1): one result appears on o_segments / o_digit_select with
// o_strobe high for one cycle, the cycle after the scan is taken. Scans may
// follow back to back; busy stays low.
// Throughput: one scan per cycle while busy is low; a new load is taken only
// after the six divide steps of the last one, bounded by the shared divider.
// Reset (i_rst_n low, synchronous) blanks all six digits and stops any load.
// The receiver cannot stall: each result is valid for its strobe cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_pair_seven_segment_scan_core (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic                                    i_cmd,
    input  wire logic signed [sps_pkg::VALUE_W-1:0]      i_first_value,
    input  wire logic signed [sps_pkg::VALUE_W-1:0]      i_second_value,
    input  wire logic        [sps_pkg::POS_W-1:0]        i_digit_index,
    output logic                                         o_strobe,
    output logic             [sps_pkg::SEG_W-1:0]        o_segments,
    output logic             [sps_pkg::NUM_DIGITS-1:0]   o_digit_select
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    logic [sps_pkg::POS_W-1:0]     r_pos;
    logic [sps_pkg::VALUE_W-1:0]   r_mag;
    logic                          r_neg;
    logic [sps_pkg::VALUE_W-1:0]   r_second;

    logic                          accept;
    logic                          load_go;
    logic                          scan_go;
    logic                          group_top;
    logic [sps_pkg::VALUE_W-1:0]   quot;
    logic [sps_pkg::CODE_W-1:0]    rem;
    sps_pkg::t_wr                  wr;

    // Magnitude of a signed value as unsigned; the most negative maps to 32768
    function automatic logic [sps_pkg::VALUE_W-1:0] mag_of(
        input logic [sps_pkg::VALUE_W-1:0] v
    );
        return v[sps_pkg::VALUE_W-1] ? (sps_pkg::VALUE_W'(0) - v) : v;
    endfunction

    assign accept    = start && !busy;
    assign load_go   = accept && (i_cmd == sps_pkg::CMD_LOAD);
    assign scan_go   = accept && (i_cmd == sps_pkg::CMD_SCAN);
    assign busy      = (r_state == S_LOAD);
    assign group_top = (r_pos == sps_pkg::POS_FIRST_TOP)
                    || (r_pos == sps_pkg::POS_SECOND_TOP);

    // Shared divider
    sps_div10 u_div10 (
        .i_value (r_mag),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    // Digit write: minus code takes the top position of a negative value
    always_comb begin
        wr.en   = busy;
        wr.addr = r_pos;
        wr.code = (r_neg && group_top) ? sps_pkg::CODE_MINUS : rem;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (load_go) n_state = S_LOAD;
            S_LOAD: if (r_pos == sps_pkg::POS_SECOND_TOP) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (load_go) begin
                r_pos <= '0;
            end else if (busy) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Working magnitude: next digit each step, second value after the first
    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_mag    <= mag_of(i_first_value);
            r_neg    <= i_first_value[sps_pkg::VALUE_W-1];
            r_second <= i_second_value;
        end else if (busy) begin
            if (r_pos == sps_pkg::POS_FIRST_TOP) begin
                r_mag <= mag_of(r_second);
                r_neg <= r_second[sps_pkg::VALUE_W-1];
            end else begin
                r_mag <= quot;
            end
        end
    end

    sps_digit_store u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_scan         (scan_go),
        .i_scan_idx     (i_digit_index),
        .o_strobe       (o_strobe),
        .o_segments     (o_segments),
        .o_digit_select (o_digit_select)
    );

    // A result only follows a scan transaction
    a_strobe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(scan_go))
        else $error("strobe without a scan transaction");

    // A load keeps the block busy on the next cycle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_go |=> busy)
        else $error("load did not start the sequencer");

    // Position counter stays within the digit range while loading
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_pos <= sps_pkg::POS_SECOND_TOP))
        else $error("load position out of range");

    // Sequencer returns to idle right after the last digit
    a_load_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (r_pos == sps_pkg::POS_SECOND_TOP)) |=> !busy)
        else $error("load did not finish after the last digit");

endmodule

`default_nettype wire
